FILE: rtl/lamp_button_mode_controller_defines.svh
// Assertion macros for the lamp button mode controller.
// Included by the top level; depends on nothing else.
`ifndef LAMP_BUTTON_MODE_CONTROLLER_DEFINES_SVH
`define LAMP_BUTTON_MODE_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lbm_pkg.sv
// Shared widths, reset values and unit request/response types for the
// lamp button mode controller. No dependencies.
package lbm_pkg;

  // Field widths.
  localparam int LBM_HOLD_W   = 24;
  localparam int LBM_CFG_W    = 16;
  localparam int LBM_BRIGHT_W = 8;

  // Serial multiplier: wide operand times an 8-bit operand.
  localparam int LBM_MUL_A_W   = 24;
  localparam int LBM_MUL_B_W   = 8;
  localparam int LBM_PROD_W    = LBM_MUL_A_W + LBM_MUL_B_W;
  localparam int LBM_MUL_CNT_W = $clog2(LBM_MUL_B_W);

  // Serial divider: 32-bit dividend, 24-bit divisor.
  localparam int LBM_DIV_N_W   = 32;
  localparam int LBM_DIV_D_W   = 24;
  localparam int LBM_DIV_CNT_W = $clog2(LBM_DIV_N_W);

  // Brightness limits and reset values.
  localparam logic [LBM_BRIGHT_W-1:0] LBM_BRIGHT_MAX   = 8'd255;
  localparam logic [LBM_BRIGHT_W-1:0] LBM_BRIGHT_RESET = 8'd50;

  localparam logic [LBM_CFG_W-1:0]    LBM_HOLD_MIN_RST = 16'd500;
  localparam logic [LBM_CFG_W-1:0]    LBM_RAMP_RST     = 16'd4000;
  localparam logic [LBM_CFG_W-1:0]    LBM_PERIOD_RST   = 16'd10000;
  localparam logic [LBM_BRIGHT_W-1:0] LBM_MIN_BRT_RST  = 8'd15;

  typedef struct packed {
    logic                   start;
    logic [LBM_MUL_A_W-1:0] a;
    logic [LBM_MUL_B_W-1:0] b;
  } lbm_mul_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [LBM_PROD_W-1:0] prod;
  } lbm_mul_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [LBM_DIV_N_W-1:0] num;
    logic [LBM_DIV_D_W-1:0] den;
  } lbm_div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [LBM_DIV_N_W-1:0] quo;
    logic [LBM_DIV_D_W-1:0] rem;
  } lbm_div_rsp_t;

endpackage

FILE: rtl/lbm_mul.sv
// Bit-serial shift-add multiplier, one bit of the narrow operand per cycle.
// Depends on lbm_pkg.
module lbm_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbm_pkg::lbm_mul_req_t req_i,
  output lbm_pkg::lbm_mul_rsp_t rsp_o
);

  logic [lbm_pkg::LBM_MUL_A_W-1:0]   a_q;
  logic [lbm_pkg::LBM_MUL_B_W-1:0]   b_q;
  logic [lbm_pkg::LBM_PROD_W-1:0]    acc_q;
  logic [lbm_pkg::LBM_MUL_CNT_W-1:0] cnt_q;
  logic                              busy_q;
  logic                              done_q;
  logic [lbm_pkg::LBM_PROD_W-1:0]    addend;

  // The multiplicand is added when the current top bit of the multiplier is set.
  assign addend = b_q[lbm_pkg::LBM_MUL_B_W-1] ? lbm_pkg::LBM_PROD_W'(a_q) : '0;

  // Multiplier bits are consumed from the top, the product shifts left each step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= {acc_q[lbm_pkg::LBM_PROD_W-2:0], 1'b0} + addend;
        b_q   <= {b_q[lbm_pkg::LBM_MUL_B_W-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lbm_pkg::LBM_MUL_CNT_W'(lbm_pkg::LBM_MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

FILE: rtl/lbm_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on lbm_pkg.
module lbm_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lbm_pkg::lbm_div_req_t req_i,
  output lbm_pkg::lbm_div_rsp_t rsp_o
);

  logic [lbm_pkg::LBM_DIV_N_W-1:0]   n_q;
  logic [lbm_pkg::LBM_DIV_D_W-1:0]   d_q;
  logic [lbm_pkg::LBM_DIV_D_W-1:0]   r_q;
  logic [lbm_pkg::LBM_DIV_CNT_W-1:0] cnt_q;
  logic                              busy_q;
  logic                              done_q;
  logic [lbm_pkg::LBM_DIV_D_W:0]     trial;
  logic [lbm_pkg::LBM_DIV_D_W:0]     diff;
  logic                              fits;

  // Bring down the next dividend bit and try a subtraction.
  assign trial = {r_q, n_q[lbm_pkg::LBM_DIV_N_W-1]};
  assign fits  = (trial >= {1'b0, d_q});
  assign diff  = trial - {1'b0, d_q};

  // The dividend register fills with quotient bits from the bottom.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      d_q    <= '0;
      r_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        n_q    <= req_i.num;
        d_q    <= req_i.den;
        r_q    <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        n_q   <= {n_q[lbm_pkg::LBM_DIV_N_W-2:0], fits};
        r_q   <= fits ? diff[lbm_pkg::LBM_DIV_D_W-1:0] : trial[lbm_pkg::LBM_DIV_D_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == lbm_pkg::LBM_DIV_CNT_W'(lbm_pkg::LBM_DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = n_q;
  assign rsp_o.rem  = r_q;

endmodule

FILE: rtl/lamp_button_mode_controller.sv
// Top level of the lamp button mode controller: lamp state, event sequencer.
// Depends on lbm_pkg, lbm_mul, lbm_div and lamp_button_mode_controller_defines.svh.
//
//  Channel | Direction | Handshake             | Word
//  in      | input     | in_valid_i/in_stall_o | req_type, click_count, hold_ms
//  out     | output    | out_valid_o/out_stall_i | lamp state snapshot
//  cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word at a time. Clicks, hold ends and trivial holds go from DECODE to EMIT.
// A brightness ramp: R_MUL1, R_DIV1 and, unless of zero length, R_MUL2, R_DIV2.
// A colour sweep: C_MUL1, C_DIV1, C_MOD, C_MUL2, C_DIV2; serial units in series.
// Reset clears all state asynchronously; no clearing pass is needed.
// A finished word waits in the output register while the next input is accepted.
`include "lamp_button_mode_controller_defines.svh"

module lamp_button_mode_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [2:0]  click_count_i,
  input  logic [23:0] hold_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        lamp_on_o,
  output logic [2:0]  color_mode_o,
  output logic [1:0]  color_substate_o,
  output logic [7:0]  brightness_out_o,
  output logic [7:0]  color_index_out_o,
  output logic        show_battery_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  typedef enum logic [1:0] {
    CFG_HOLD_MIN   = 2'd0,
    CFG_RAMP       = 2'd1,
    CFG_PERIOD     = 2'd2,
    CFG_MIN_BRIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_R_MUL1,
    ST_R_DIV1,
    ST_R_MUL2,
    ST_R_DIV2,
    ST_C_MUL1,
    ST_C_DIV1,
    ST_C_MOD,
    ST_C_MUL2,
    ST_C_DIV2,
    ST_EMIT
  } state_e;

  localparam logic       REQ_CLICK  = 1'b0;
  localparam logic [2:0] N_NONE     = 3'd0;
  localparam logic [2:0] N_TOGGLE   = 3'd1;
  localparam logic [2:0] N_SUBSTATE = 3'd2;
  localparam logic [2:0] N_MODE_UP  = 3'd3;
  localparam logic [2:0] N_MODE_DN  = 3'd4;
  localparam logic [2:0] N_BATTERY  = 3'd5;
  localparam logic [2:0] MODE_MAX   = 3'd4;

  // Highest sub-state of each mode.
  function automatic logic [2:0] sub_max(input logic [2:0] mode);
    logic [2:0] mx;
    unique case (mode)
      3'd0:    mx = 3'd1;
      3'd1:    mx = 3'd3;
      3'd2:    mx = 3'd2;
      3'd3:    mx = 3'd1;
      default: mx = 3'd0;
    endcase
    return mx;
  endfunction

  // Step the sub-state, wrapping one past the maximum to zero and clamping beyond it.
  function automatic logic [1:0] sub_next(input logic [2:0] mode, input logic [1:0] sub);
    logic [2:0] v;
    logic [2:0] mx;
    logic [2:0] r;
    v  = {1'b0, sub} + 3'd1;
    mx = sub_max(mode);
    if (v == mx + 3'd1) r = 3'd0;
    else if (v > mx)    r = mx;
    else                r = v;
    return r[1:0];
  endfunction

  function automatic logic [2:0] mode_up(input logic [2:0] mode);
    logic [3:0] v;
    logic [2:0] r;
    v = {1'b0, mode} + 4'd1;
    if (v == {1'b0, MODE_MAX} + 4'd1) r = 3'd0;
    else if (v > {1'b0, MODE_MAX})    r = MODE_MAX;
    else                              r = v[2:0];
    return r;
  endfunction

  function automatic logic [2:0] mode_down(input logic [2:0] mode);
    logic [2:0] v;
    logic [2:0] r;
    v = mode - 3'd1;
    if (mode == 3'd0)     r = MODE_MAX;
    else if (v > MODE_MAX) r = MODE_MAX;
    else                  r = v;
    return r;
  endfunction

  // Configuration registers.
  logic [15:0] hold_min_q;
  logic [15:0] ramp_q;
  logic [15:0] period_q;
  logic [7:0]  min_bright_q;

  // Lamp state.
  logic       active_q;
  logic [2:0] mode_q;
  logic [1:0] sub_q;
  logic [7:0] bright_q;
  logic [7:0] base_q;
  logic [7:0] index_q;
  logic [7:0] saved_q;
  logic       battery_q;

  // Latched event and working values.
  state_e      state_q;
  logic        req_q;
  logic [2:0]  cnt_q;
  logic [23:0] hold_q;
  logic [23:0] d_q;
  logic [15:0] p_q;
  logic [7:0]  gap_q;
  logic [23:0] len_q;

  // Output register.
  logic       out_valid_q;
  logic       lamp_on_q;
  logic [2:0] color_mode_q;
  logic [1:0] color_sub_q;
  logic [7:0] brightness_q;
  logic [7:0] color_index_q;
  logic       show_battery_q;

  lbm_pkg::lbm_mul_req_t mul_req_q;
  lbm_pkg::lbm_mul_rsp_t mul_rsp;
  lbm_pkg::lbm_div_req_t div_req_q;
  lbm_pkg::lbm_div_rsp_t div_rsp;

  logic        in_accept;
  logic        out_free;
  logic        ending;
  logic        up;
  logic [23:0] d_sat;
  logic [15:0] p_eff;
  logic [7:0]  range_w;
  logic [7:0]  gap_up;
  logic [7:0]  gap_dn;
  logic [7:0]  gap_sel;
  logic [7:0]  ramp_target;
  logic [23:0] len_w;
  logic [23:0] x_sel;
  logic [15:0] shift_w;
  logic [31:0] num_c;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  // Hold time after the minimum, ramp gaps and the effective colour period.
  always_comb begin
    ending      = (hold_q[23:1] == 23'd0);
    up          = (cnt_q == N_TOGGLE);
    d_sat       = (hold_q > {8'd0, hold_min_q}) ? hold_q - {8'd0, hold_min_q} : 24'd0;
    p_eff       = (period_q == 16'd0) ? 16'd1 : period_q;
    range_w     = lbm_pkg::LBM_BRIGHT_MAX - min_bright_q;
    gap_up      = lbm_pkg::LBM_BRIGHT_MAX - base_q;
    gap_dn      = (base_q > min_bright_q) ? base_q - min_bright_q : 8'd0;
    gap_sel     = up ? gap_up : gap_dn;
    ramp_target = up ? lbm_pkg::LBM_BRIGHT_MAX : min_bright_q;
    len_w       = div_rsp.quo[23:0];
    x_sel       = (d_q < len_w) ? d_q : len_w;
    shift_w     = div_rsp.quo[15:0];
    if (cnt_q == N_MODE_UP) begin
      num_c = 32'(d_q) + 32'(shift_w);
    end else if (d_q < {8'd0, shift_w}) begin
      num_c = {16'd0, p_q - (shift_w - d_q[15:0])};
    end else begin
      num_c = {8'd0, d_q - {8'd0, shift_w}};
    end
  end

  // Configuration writes must only be issued while the block is idle; unchecked here.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_min_q   <= lbm_pkg::LBM_HOLD_MIN_RST;
      ramp_q       <= lbm_pkg::LBM_RAMP_RST;
      period_q     <= lbm_pkg::LBM_PERIOD_RST;
      min_bright_q <= lbm_pkg::LBM_MIN_BRT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HOLD_MIN:   hold_min_q   <= cfg_data_i;
        CFG_RAMP:       ramp_q       <= cfg_data_i;
        CFG_PERIOD:     period_q     <= cfg_data_i;
        CFG_MIN_BRIGHT: min_bright_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Event sequencer with lamp state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      active_q       <= 1'b0;
      mode_q         <= 3'd0;
      sub_q          <= 2'd0;
      bright_q       <= lbm_pkg::LBM_BRIGHT_RESET;
      base_q         <= lbm_pkg::LBM_BRIGHT_RESET;
      index_q        <= 8'd0;
      saved_q        <= 8'd0;
      battery_q      <= 1'b0;
      req_q          <= REQ_CLICK;
      cnt_q          <= N_NONE;
      hold_q         <= 24'd0;
      d_q            <= 24'd0;
      p_q            <= 16'd1;
      gap_q          <= 8'd0;
      len_q          <= 24'd0;
      mul_req_q      <= '0;
      div_req_q      <= '0;
      out_valid_q    <= 1'b0;
      lamp_on_q      <= 1'b0;
      color_mode_q   <= 3'd0;
      color_sub_q    <= 2'd0;
      brightness_q   <= lbm_pkg::LBM_BRIGHT_RESET;
      color_index_q  <= 8'd0;
      show_battery_q <= 1'b0;
    end else begin
      mul_req_q.start <= 1'b0;
      div_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            req_q   <= req_type_i;
            cnt_q   <= click_count_i;
            hold_q  <= hold_ms_i;
            state_q <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          state_q <= ST_EMIT;
          if (req_q == REQ_CLICK) begin
            // Click release: all updates settle here.
            if (cnt_q != N_NONE) begin
              battery_q <= (cnt_q == N_BATTERY);
            end
            case (cnt_q) inside
              N_TOGGLE: begin
                active_q <= ~active_q;
                index_q  <= 8'd0;
                saved_q  <= 8'd0;
              end
              N_SUBSTATE: begin
                if (active_q) begin
                  sub_q   <= sub_next(mode_q, sub_q);
                  index_q <= 8'd0;
                  saved_q <= 8'd0;
                end
              end
              N_MODE_UP, N_MODE_DN: begin
                if (active_q) begin
                  mode_q  <= (cnt_q == N_MODE_UP) ? mode_up(mode_q) : mode_down(mode_q);
                  sub_q   <= 2'd0;
                  index_q <= 8'd0;
                  saved_q <= 8'd0;
                end
              end
              default: ;
            endcase
          end else if (cnt_q != N_NONE && active_q) begin
            // Hold event on a lit lamp.
            battery_q <= 1'b0;
            d_q       <= d_sat;
            p_q       <= p_eff;
            case (cnt_q) inside
              N_TOGGLE, N_SUBSTATE: begin
                gap_q <= gap_sel;
                if (ending) begin
                  base_q <= bright_q;
                end else if (gap_sel == 8'd0) begin
                  bright_q <= base_q;
                end else if (range_w == 8'd0) begin
                  bright_q <= ramp_target;
                end else begin
                  mul_req_q <= '{start: 1'b1, a: {8'd0, ramp_q}, b: gap_sel};
                  state_q   <= ST_R_MUL1;
                end
              end
              N_MODE_UP, N_MODE_DN: begin
                if (ending) begin
                  saved_q <= index_q;
                end else begin
                  mul_req_q <= '{start: 1'b1, a: {8'd0, p_eff}, b: saved_q};
                  state_q   <= ST_C_MUL1;
                end
              end
              default: ;
            endcase
          end
        end

        // Ramp length: ramp_ms * gap / range.
        ST_R_MUL1: begin
          if (mul_rsp.done) begin
            div_req_q <= '{start: 1'b1, num: mul_rsp.prod, den: {16'd0, range_w}};
            state_q   <= ST_R_DIV1;
          end
        end

        ST_R_DIV1: begin
          if (div_rsp.done) begin
            len_q <= len_w;
            if (len_w == 24'd0) begin
              bright_q <= ramp_target;
              state_q  <= ST_EMIT;
            end else begin
              mul_req_q <= '{start: 1'b1, a: x_sel, b: gap_q};
              state_q   <= ST_R_MUL2;
            end
          end
        end

        // Brightness offset: min(d, len) * gap / len.
        ST_R_MUL2: begin
          if (mul_rsp.done) begin
            div_req_q <= '{start: 1'b1, num: mul_rsp.prod, den: len_q};
            state_q   <= ST_R_DIV2;
          end
        end

        ST_R_DIV2: begin
          if (div_rsp.done) begin
            bright_q <= up ? base_q + div_rsp.quo[7:0] : base_q - div_rsp.quo[7:0];
            state_q  <= ST_EMIT;
          end
        end

        // Sweep phase: period * saved_index / 255.
        ST_C_MUL1: begin
          if (mul_rsp.done) begin
            div_req_q <= '{start: 1'b1, num: mul_rsp.prod,
                           den: 24'(lbm_pkg::LBM_BRIGHT_MAX)};
            state_q   <= ST_C_DIV1;
          end
        end

        ST_C_DIV1: begin
          if (div_rsp.done) begin
            div_req_q <= '{start: 1'b1, num: num_c, den: {8'd0, p_q}};
            state_q   <= ST_C_MOD;
          end
        end

        // Position within the period, scaled to 0..254.
        ST_C_MOD: begin
          if (div_rsp.done) begin
            mul_req_q <= '{start: 1'b1, a: {8'd0, div_rsp.rem[15:0]},
                           b: lbm_pkg::LBM_BRIGHT_MAX};
            state_q   <= ST_C_MUL2;
          end
        end

        ST_C_MUL2: begin
          if (mul_rsp.done) begin
            div_req_q <= '{start: 1'b1, num: mul_rsp.prod, den: {8'd0, p_q}};
            state_q   <= ST_C_DIV2;
          end
        end

        ST_C_DIV2: begin
          if (div_rsp.done) begin
            index_q <= (cnt_q == N_MODE_UP) ? div_rsp.quo[7:0]
                                            : lbm_pkg::LBM_BRIGHT_MAX - div_rsp.quo[7:0];
            state_q <= ST_EMIT;
          end
        end

        // Hand the state to the output register once it is free.
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            lamp_on_q      <= active_q;
            color_mode_q   <= mode_q;
            color_sub_q    <= sub_q;
            brightness_q   <= bright_q;
            color_index_q  <= index_q;
            show_battery_q <= battery_q;
            state_q        <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  lbm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  lbm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign lamp_on_o         = lamp_on_q;
  assign color_mode_o      = color_mode_q;
  assign color_substate_o  = color_sub_q;
  assign brightness_out_o  = brightness_q;
  assign color_index_out_o = color_index_q;
  assign show_battery_o    = show_battery_q;

  // Checks on the sequencer, the output word and the shared divider.
  `LBM_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, in_stall_o, "no stall after accept")
  `LBM_ASSERT_NOW(a_mode_range, clk_i, rst_ni, out_valid_o, color_mode_o <= MODE_MAX, "mode range")
  `LBM_ASSERT_NOW(a_sub_range, clk_i, rst_ni, out_valid_o, {1'b0, color_substate_o} <= sub_max(color_mode_o), "substate range")
  `LBM_ASSERT_NOW(a_div_idle, clk_i, rst_ni, div_req_q.start, !div_rsp.busy, "divider restarted while busy")

endmodule

FILE: tb/lamp_button_mode_controller_test.sv
// Self-checking testbench for the lamp button mode controller: directed and random
// button events under several register settings, with random input gaps and stalls.
// Depends on lbm_pkg and the lamp_button_mode_controller RTL.
`timescale 1ns / 100ps

module lamp_button_mode_controller_test;

  typedef enum logic {PRESS_CLICK, PRESS_HOLD} press_kind_e;

  typedef enum logic [2:0] {
    NO_CLICK, ONE_CLICK, TWO_CLICKS, THREE_CLICKS,
    FOUR_CLICKS, FIVE_CLICKS, SIX_CLICKS, SEVEN_CLICKS
  } clicks_e;

  typedef enum logic [1:0] {REG_HOLD_MIN, REG_RAMP, REG_PERIOD, REG_MIN_BRT} lamp_reg_e;

  // Highest colour mode; modes wrap between it and 0.
  localparam logic [2:0] MODE_LAST = 3'd4;
  // Cycles without any word moving before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  // One result word, in port order.
  typedef struct packed {
    logic       lamp_on;
    logic [2:0] mode;
    logic [1:0] sub;
    logic [7:0] bright;
    logic [7:0] index;
    logic       battery;
  } lamp_view_t;

  // Lamp state predictor and the queue of words it expects.
  class lamp_scoreboard;
    bit [15:0]  hold_min, ramp_span_ms, period_ms;
    bit [7:0]   min_brt;
    bit         active, battery;
    bit [2:0]   mode;
    bit [1:0]   sub;
    bit [7:0]   bright, base_bright, index, saved_index;
    lamp_view_t expected_q[$];
    int         errors;

    function new();
      hold_min     = lbm_pkg::LBM_HOLD_MIN_RST;
      ramp_span_ms = lbm_pkg::LBM_RAMP_RST;
      period_ms    = lbm_pkg::LBM_PERIOD_RST;
      min_brt      = lbm_pkg::LBM_MIN_BRT_RST;
      active       = 1'b0;
      battery      = 1'b0;
      mode         = '0;
      sub          = '0;
      bright       = lbm_pkg::LBM_BRIGHT_RESET;
      base_bright  = lbm_pkg::LBM_BRIGHT_RESET;
      index        = '0;
      saved_index  = '0;
      errors       = 0;
    endfunction

    function void set_reg(lamp_reg_e sel, bit [15:0] value);
      case (sel)
        REG_HOLD_MIN: hold_min = value;
        REG_RAMP:     ramp_span_ms = value;
        REG_PERIOD:   period_ms = value;
        REG_MIN_BRT:  min_brt = value[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Apply one accepted button word to the state and queue the resulting snapshot.
    function void note_event(bit is_hold, bit [2:0] clicks, bit [23:0] hold_ms);
      bit [31:0]  d, p, shift, step, span, gap, len, x, sub_next, sub_top;
      lamp_view_t want;
      if (!is_hold) begin
        if (clicks != NO_CLICK) begin
          battery = 1'b0;
          case (clicks)
            ONE_CLICK: begin
              active = !active;
              index = '0;
              saved_index = '0;
            end
            TWO_CLICKS: if (active) begin
              case (mode)
                3'd0: sub_top = 1;
                3'd1: sub_top = 3;
                3'd2: sub_top = 2;
                3'd3: sub_top = 1;
                default: sub_top = 0;
              endcase
              // One past the maximum wraps to 0; anything further clamps.
              sub_next = sub + 32'd1;
              if (sub_next == sub_top + 1) sub = '0;
              else if (sub_next > sub_top) sub = sub_top[1:0];
              else sub = sub_next[1:0];
              index = '0;
              saved_index = '0;
            end
            THREE_CLICKS, FOUR_CLICKS: if (active) begin
              if (clicks == THREE_CLICKS) mode = (mode == MODE_LAST) ? 3'd0 : mode + 3'd1;
              else mode = (mode == 3'd0) ? MODE_LAST : mode - 3'd1;
              sub = '0;
              index = '0;
              saved_index = '0;
            end
            FIVE_CLICKS: battery = 1'b1;
            default: ;
          endcase
        end
      end else if (clicks != NO_CLICK && active) begin
        battery = 1'b0;
        d     = (hold_ms > hold_min) ? hold_ms - hold_min : 32'd0;
        p     = (period_ms == 0) ? 32'd1 : period_ms;
        shift = (p * saved_index) / 32'd255;
        case (clicks)
          ONE_CLICK, TWO_CLICKS: begin
            if (hold_ms <= 1) begin
              base_bright = bright;
            end else begin
              span = 32'd255 - min_brt;
              if (clicks == ONE_CLICK) gap = 32'd255 - base_bright;
              else gap = (base_bright > min_brt) ? base_bright - min_brt : 32'd0;
              if (gap == 0) begin
                bright = base_bright;
              end else begin
                len = (span == 0) ? 32'd0 : (ramp_span_ms * gap) / span;
                // A ramp of zero length lands on its target at once.
                if (len == 0) begin
                  bright = (clicks == ONE_CLICK) ? 8'd255 : min_brt;
                end else begin
                  x = (d < len) ? d : len;
                  x = (x * gap) / len;
                  bright = 8'((clicks == ONE_CLICK) ? base_bright + x : base_bright - x);
                end
              end
            end
          end
          THREE_CLICKS: begin
            if (hold_ms <= 1) begin
              saved_index = index;
            end else begin
              step  = (d + shift) % p;
              index = 8'((step * 32'd255) / p);
            end
          end
          FOUR_CLICKS: begin
            if (hold_ms <= 1) begin
              saved_index = index;
            end else begin
              step  = (d < shift) ? p - (shift - d) : d - shift;
              step  = step % p;
              index = 8'(32'd255 - (step * 32'd255) / p);
            end
          end
          default: ;
        endcase
      end
      want = '{active, mode, sub, bright, index, battery};
      expected_q.push_back(want);
    endfunction

    function void compare_field(string field, bit [7:0] want, bit [7:0] got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(lamp_view_t got);
      lamp_view_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with none expected, got %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("lamp_on", 8'(want.lamp_on), 8'(got.lamp_on));
      compare_field("color_mode", 8'(want.mode), 8'(got.mode));
      compare_field("color_substate", 8'(want.sub), 8'(got.sub));
      compare_field("brightness_out", want.bright, got.bright);
      compare_field("color_index_out", want.index, got.index);
      compare_field("show_battery", 8'(want.battery), 8'(got.battery));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [2:0]  click_count_i = '0;
  logic [23:0] hold_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        lamp_on_o;
  logic [2:0]  color_mode_o;
  logic [1:0]  color_substate_o;
  logic [7:0]  brightness_out_o;
  logic [7:0]  color_index_out_o;
  logic        show_battery_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  lamp_scoreboard sb;
  bit             idle_en = 1'b1;
  int             sent_count = 0;
  int             stall_left = 0;
  int             quiet_cycles = 0;

  lamp_button_mode_controller uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .click_count_i     (click_count_i),
    .hold_ms_i         (hold_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .lamp_on_o         (lamp_on_o),
    .color_mode_o      (color_mode_o),
    .color_substate_o  (color_substate_o),
    .brightness_out_o  (brightness_out_o),
    .color_index_out_o (color_index_out_o),
    .show_battery_o    (show_battery_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Result side: check each accepted word, then stall the next one for a random count.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else if (out_valid_o && !out_stall_i) begin
      sb.check_result({lamp_on_o, color_mode_o, color_substate_o, brightness_out_o,
                       color_index_out_o, show_battery_o});
      stall_left = idle_en ? $urandom_range(0, 8) : 0;
      out_stall_i <= (stall_left != 0);
    end else if (out_valid_o && out_stall_i) begin
      stall_left = stall_left - 1;
      if (stall_left <= 0) out_stall_i <= 1'b0;
    end
  end

  // Hang detection: no word moved on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one button word after a random gap and wait until it is taken.
  task automatic send_event(press_kind_e kind, bit [2:0] clicks, bit [23:0] hold_ms);
    int gap;
    gap = idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    click_count_i <= clicks;
    hold_ms_i     <= hold_ms;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(kind == PRESS_HOLD, clicks, hold_ms);
    sent_count++;
  endtask

  // Stop offering words and wait until every expected result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(lamp_reg_e sel, bit [15:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(sel, value);
  endtask

  task automatic apply_settings(bit [15:0] hold_min, bit [15:0] ramp_span,
                                bit [15:0] period, bit [7:0] min_level);
    settle();
    write_reg(REG_HOLD_MIN, hold_min);
    write_reg(REG_RAMP, ramp_span);
    write_reg(REG_PERIOD, period);
    write_reg(REG_MIN_BRT, {8'd0, min_level});
  endtask

  // Mostly complete hold gestures and clicks with the lamp kept on, plus some noise
  // and holds that never see their release.
  task automatic run_random(int n);
    int       first, kind, steps;
    bit [23:0] t;
    bit [2:0]  c;
    first = sent_count;
    while (sent_count - first < n) begin
      kind = $urandom_range(0, 9);
      if (!sb.active && kind < 8 && $urandom_range(0, 3) != 0) begin
        send_event(PRESS_CLICK, ONE_CLICK, 24'($urandom));
      end else if (kind < 5 || kind == 9) begin
        c     = 3'($urandom_range(1, 4));
        steps = $urandom_range(1, 6);
        t     = 24'($urandom_range(0, 3000));
        repeat (steps) begin
          if ($urandom_range(0, 7) == 0) t = 24'($urandom);
          else t = 24'(t + $urandom_range(0, 4000));
          send_event(PRESS_HOLD, c, t);
        end
        if (kind != 9) send_event(PRESS_HOLD, c, 24'($urandom_range(0, 1)));
      end else if (kind < 8) begin
        send_event(PRESS_CLICK, 3'($urandom_range(1, 5)), 24'($urandom));
      end else begin
        send_event(press_kind_e'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                   24'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset settings: ignored words, battery request and its
    // clearing, ramps to both ends, zero gap, wraps and sweeps both ways.
    send_event(PRESS_CLICK, NO_CLICK, 24'hFFFFFF);
    send_event(PRESS_HOLD, ONE_CLICK, 24'd3000);
    send_event(PRESS_CLICK, FIVE_CLICKS, 24'd0);
    send_event(PRESS_CLICK, SIX_CLICKS, 24'd0);
    send_event(PRESS_CLICK, FIVE_CLICKS, 24'd0);
    send_event(PRESS_CLICK, TWO_CLICKS, 24'd0);
    send_event(PRESS_CLICK, ONE_CLICK, 24'd0);
    send_event(PRESS_HOLD, NO_CLICK, 24'd5000);
    send_event(PRESS_CLICK, FIVE_CLICKS, 24'd0);
    send_event(PRESS_HOLD, FIVE_CLICKS, 24'd2);
    send_event(PRESS_HOLD, ONE_CLICK, 24'hFFFFFF);
    send_event(PRESS_HOLD, ONE_CLICK, 24'd1);
    send_event(PRESS_HOLD, ONE_CLICK, 24'd800);
    send_event(PRESS_HOLD, TWO_CLICKS, 24'd2);
    send_event(PRESS_HOLD, TWO_CLICKS, 24'd2000);
    send_event(PRESS_HOLD, TWO_CLICKS, 24'd0);
    send_event(PRESS_CLICK, TWO_CLICKS, 24'd0);
    send_event(PRESS_CLICK, TWO_CLICKS, 24'd0);
    send_event(PRESS_CLICK, FOUR_CLICKS, 24'd0);
    send_event(PRESS_CLICK, THREE_CLICKS, 24'd0);
    send_event(PRESS_HOLD, THREE_CLICKS, 24'd7000);
    send_event(PRESS_HOLD, THREE_CLICKS, 24'd1);
    send_event(PRESS_HOLD, FOUR_CLICKS, 24'd600);
    send_event(PRESS_HOLD, FOUR_CLICKS, 24'd40000);
    send_event(PRESS_HOLD, FOUR_CLICKS, 24'd0);
    send_event(PRESS_HOLD, SIX_CLICKS, 24'd0);
    send_event(PRESS_CLICK, SEVEN_CLICKS, 24'd0);
    run_random(150);

    // Extremes of every register, then zero period with a full-scale floor.
    apply_settings(16'd0, 16'd1, 16'd1, 8'd0);
    run_random(125);
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254);
    idle_en = 1'b0;
    run_random(125);
    apply_settings(16'd500, 16'd4000, 16'd0, 8'd255);
    idle_en = 1'b1;
    run_random(125);
    apply_settings(16'd100, 16'd300, 16'd256, 8'd200);
    run_random(125);
    apply_settings(16'($urandom_range(0, 3000)), 16'($urandom_range(1, 65535)),
                   16'($urandom_range(1, 20000)), 8'($urandom_range(0, 254)));
    run_random(125);
    apply_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 8000)),
                   16'($urandom_range(1, 65535)), 8'($urandom_range(0, 254)));
    run_random(125);

    // Drain, then give any stray word time to show up.
    settle();
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
